// ===== hw/rtl/bba_pkg.sv =====
// Shared types and constants of the bitmap block allocator.
package bba_pkg;

  // Field widths and bitmap organisation.
  localparam int unsigned INDEX_W    = 12;
  localparam int unsigned COUNT_W    = 13;
  localparam int unsigned WORD_BITS  = 64;
  localparam int unsigned POS_W      = 6;
  localparam int unsigned INDEX_SPAN = 4096;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd4096;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_SCAN,
    S_CLEAR
  } state_e;

  typedef struct packed {
    cmd_e               command;
    logic [INDEX_W-1:0] block_index;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [INDEX_W-1:0] allocated_index;
  } rsp_t;

  // Outcome of one pass of the word scan unit.
  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] pos;
  } scan_t;

endpackage

// ===== hw/rtl/bba_ram.sv =====
// Generic single-port RAM with a registered read.
module bba_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One access per cycle: a write, or a read whose data appear next cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/bba_word_scan.sv =====
// Finds the lowest free block within one bitmap word, below a bit limit.
module bba_word_scan (
  input  logic [bba_pkg::WORD_BITS-1:0] word_i,
  input  logic [bba_pkg::COUNT_W-1:0]   rem_i,
  output bba_pkg::scan_t                scan_o
);

  import bba_pkg::*;

  logic [WORD_BITS-1:0] free_vec;
  logic [WORD_BITS-1:0] lowest;
  logic [POS_W-1:0]     pos;

  // A bit is a candidate when it is clear and lies below the remaining limit.
  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      free_vec[b] = ~word_i[b] && (COUNT_W'(b) < rem_i);
    end
  end

  // Isolate the lowest candidate and encode its position.
  assign lowest = free_vec & (~free_vec + WORD_BITS'(1));

  always_comb begin
    pos = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (lowest[b]) begin
        pos = pos | POS_W'(b);
      end
    end
  end

  assign scan_o.found = |free_vec;
  assign scan_o.pos   = pos;

endmodule

// ===== hw/rtl/bitmap_block_allocator.sv =====
// First-fit bitmap block allocator: top level with sequencer and bitmap RAM.
//
// The bitmap is held as 64-bit words in a single-port RAM and examined one word per cycle by a
// single scan unit. After a transaction is accepted (start high while busy is low) the issue
// state makes the range check and the first RAM read. An allocate then scans words in the scan
// state, up to ceil(limit/64) words, where limit is the smaller of block_count and the map size;
// a free instead passes through the clear state for its read-modify-write. done_o is registered
// from the state that ends the transaction: the issue state for a rejected one, the clear state
// for a free, the scan state for an allocate. It is high for one cycle and cannot be held off;
// rsp_o gives the result in that cycle and keeps it until a later result. busy is already low in
// that cycle, so the next transaction may be accepted at its end. The bitmap needs no clearing
// pass after reset: each word carries a valid flag, and a word never written reads as all free.
module bitmap_block_allocator #(
  parameter int unsigned MAP_BITS = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  bba_pkg::req_t                 req_i,
  output logic                          done_o,
  output bba_pkg::rsp_t                 rsp_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bba_pkg::COUNT_W-1:0]   cfg_data_i
);

  import bba_pkg::*;

  localparam int unsigned USED_BITS = (MAP_BITS < INDEX_SPAN) ? MAP_BITS : INDEX_SPAN;
  localparam int unsigned WORDS     = (USED_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW        = (WORDS > 1) ? $clog2(WORDS) : 1;

  localparam logic [COUNT_W-1:0] USED_LIMIT = COUNT_W'(USED_BITS);

  state_e               state_q, state_d;
  logic [COUNT_W-1:0]   block_count_q;
  logic [COUNT_W-1:0]   limit;
  req_t                 req_q, req_d;
  logic [COUNT_W-1:0]   lim_q, lim_d;
  logic [AW-1:0]        word_q, word_d;
  logic [WORDS-1:0]     row_valid_q;
  logic                 rd_valid_q;
  logic                 done_q, done_d;
  rsp_t                 rsp_q, rsp_d;

  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_addr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata, word_data;
  logic                 set_valid;

  logic [COUNT_W-1:0]   base, rem, base_next;
  logic                 scan_last;
  logic                 issue_range, issue_empty;
  scan_t                scan;

  // Configuration register; always ready.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_count_q <= COUNT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      block_count_q <= cfg_data_i;
    end
  end

  // Active limit: the configured count, capped at the blocks that exist.
  assign limit = (block_count_q > USED_LIMIT) ? USED_LIMIT : block_count_q;

  // Word position within the scan, and the bits of the word still below the limit.
  assign base      = COUNT_W'(word_q) << POS_W;
  assign rem       = lim_q - base;
  assign base_next = base + COUNT_W'(WORD_BITS);
  assign scan_last = (base_next >= lim_q);

  // Checks made in the issue state of a transaction.
  assign issue_range = (req_q.command == CMD_FREE) &&
                       ({1'b0, req_q.block_index} >= lim_q);
  assign issue_empty = (req_q.command == CMD_ALLOC) && (lim_q == '0);

  // A word that was never written reads as all free.
  assign word_data = rd_valid_q ? ram_rdata : '0;

  bba_word_scan u_scan (
    .word_i (word_data),
    .rem_i  (rem),
    .scan_o (scan)
  );

  bba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_ISSUE;
        end
      end
      S_ISSUE: begin
        priority if (issue_range || issue_empty) begin
          state_d = S_IDLE;
        end else if (req_q.command == CMD_FREE) begin
          state_d = S_CLEAR;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan.found || scan_last) begin
          state_d = S_IDLE;
        end
      end
      S_CLEAR: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Sequencer outputs: RAM access, latched transaction and result.
  always_comb begin
    req_d     = req_q;
    lim_d     = lim_q;
    word_d    = word_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = word_q;
    ram_wdata = word_data;
    set_valid = 1'b0;
    done_d    = 1'b0;
    rsp_d     = rsp_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          req_d  = req_i;
          lim_d  = limit;
          word_d = (req_i.command == CMD_FREE) ? AW'(req_i.block_index >> POS_W) : '0;
        end
      end
      S_ISSUE: begin
        if (issue_range || issue_empty) begin
          done_d                = 1'b1;
          rsp_d.status          = issue_range ? ST_RANGE : ST_FULL;
          rsp_d.allocated_index = '0;
        end else begin
          ram_re = 1'b1;
        end
      end
      S_SCAN: begin
        priority if (scan.found) begin
          ram_we                = 1'b1;
          ram_wdata             = word_data | (WORD_BITS'(1) << scan.pos);
          set_valid             = 1'b1;
          done_d                = 1'b1;
          rsp_d.status          = ST_OK;
          rsp_d.allocated_index = {base[INDEX_W-1:POS_W], scan.pos};
        end else if (scan_last) begin
          done_d                = 1'b1;
          rsp_d.status          = ST_FULL;
          rsp_d.allocated_index = '0;
        end else begin
          word_d   = word_q + AW'(1);
          ram_addr = word_d;
          ram_re   = 1'b1;
        end
      end
      S_CLEAR: begin
        ram_we                = 1'b1;
        ram_wdata             = word_data & ~(WORD_BITS'(1) << req_q.block_index[POS_W-1:0]);
        set_valid             = 1'b1;
        done_d                = 1'b1;
        rsp_d.status          = ST_OK;
        rsp_d.allocated_index = '0;
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      done_q      <= 1'b0;
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (set_valid) begin
        row_valid_q[ram_addr] <= 1'b1;
      end
      if (ram_re) begin
        rd_valid_q <= row_valid_q[ram_addr];
      end
    end
  end

  // Transaction and result payload.
  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    lim_q  <= lim_d;
    word_q <= word_d;
    rsp_q  <= rsp_d;
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // A result is only ever presented once the sequencer is back at rest.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (state_q == S_IDLE))
    else $error("result strobe while the sequencer is still working");

  // An allocated block always lies below the limit captured for the transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (req_q.command == CMD_ALLOC) && (rsp_o.status == ST_OK)) |->
    ({1'b0, rsp_o.allocated_index} < lim_q))
    else $error("allocated block beyond the active limit");

  // A free never reports an index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (req_q.command == CMD_FREE)) |-> (rsp_o.allocated_index == '0))
    else $error("free transaction returned a non-zero index");

  // The bitmap is written only while scanning or clearing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> ((state_q == S_SCAN) || (state_q == S_CLEAR)))
    else $error("bitmap write outside a scan or clear cycle");

  // An accepted transaction makes the block busy in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

endmodule

// ===== bench/tb_bitmap_block_allocator.sv =====
// Self-checking testbench for the first-fit bitmap block allocator.
module tb_bitmap_block_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  import bba_pkg::*;

  localparam int unsigned MAP_BITS       = 4096;
  localparam int unsigned RANDOM_ITEMS   = 1850;
  localparam int unsigned TAIL_ITEMS     = 250;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES  = 100;
  localparam int unsigned PRINT_CAP      = 50;

  // Kinds of row in the directed plan.
  typedef enum logic [1:0] {
    ROW_COUNT,
    ROW_TYPED,
    ROW_PREDICTED
  } row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [COUNT_W-1:0] count;
    req_t               req;
    rsp_t               rsp;
  } plan_row_t;

  // Directed plan: reset value, first fit, double free, zero and one block, count above the map.
  localparam plan_row_t DIRECTED_PLAN [28] = '{
    '{ROW_TYPED,     13'd0,    '{CMD_ALLOC, 12'd0},     '{ST_OK,    12'd0}},
    '{ROW_TYPED,     13'd0,    '{CMD_ALLOC, 12'hFFF},   '{ST_OK,    12'd1}},
    '{ROW_TYPED,     13'd0,    '{CMD_FREE,  12'd0},     '{ST_OK,    12'd0}},
    '{ROW_TYPED,     13'd0,    '{CMD_ALLOC, 12'd0},     '{ST_OK,    12'd0}},
    '{ROW_TYPED,     13'd0,    '{CMD_FREE,  12'hFFF},   '{ST_OK,    12'd0}},
    '{ROW_TYPED,     13'd0,    '{CMD_FREE,  12'd1},     '{ST_OK,    12'd0}},
    '{ROW_TYPED,     13'd0,    '{CMD_FREE,  12'd0},     '{ST_OK,    12'd0}},
    '{ROW_COUNT,     13'd0,    '{CMD_ALLOC, 12'd0},     '{ST_OK,    12'd0}},
    '{ROW_TYPED,     13'd0,    '{CMD_ALLOC, 12'd0},     '{ST_FULL,  12'd0}},
    '{ROW_TYPED,     13'd0,    '{CMD_FREE,  12'd0},     '{ST_RANGE, 12'd0}},
    '{ROW_TYPED,     13'd0,    '{CMD_FREE,  12'hFFF},   '{ST_RANGE, 12'd0}},
    '{ROW_COUNT,     13'd1,    '{CMD_ALLOC, 12'd0},     '{ST_OK,    12'd0}},
    '{ROW_TYPED,     13'd0,    '{CMD_ALLOC, 12'hFFF},   '{ST_OK,    12'd0}},
    '{ROW_TYPED,     13'd0,    '{CMD_ALLOC, 12'd0},     '{ST_FULL,  12'd0}},
    '{ROW_TYPED,     13'd0,    '{CMD_FREE,  12'd1},     '{ST_RANGE, 12'd0}},
    '{ROW_TYPED,     13'd0,    '{CMD_FREE,  12'd0},     '{ST_OK,    12'd0}},
    '{ROW_COUNT,     13'd8191, '{CMD_ALLOC, 12'd0},     '{ST_OK,    12'd0}},
    '{ROW_TYPED,     13'd0,    '{CMD_FREE,  12'hFFF},   '{ST_OK,    12'd0}},
    '{ROW_PREDICTED, 13'd0,    '{CMD_ALLOC, 12'd0},     '{ST_OK,    12'd0}},
    '{ROW_PREDICTED, 13'd0,    '{CMD_ALLOC, 12'd0},     '{ST_OK,    12'd0}},
    '{ROW_COUNT,     13'd2,    '{CMD_ALLOC, 12'd0},     '{ST_OK,    12'd0}},
    '{ROW_PREDICTED, 13'd0,    '{CMD_ALLOC, 12'd0},     '{ST_OK,    12'd0}},
    '{ROW_PREDICTED, 13'd0,    '{CMD_FREE,  12'd1},     '{ST_OK,    12'd0}},
    '{ROW_PREDICTED, 13'd0,    '{CMD_ALLOC, 12'd0},     '{ST_OK,    12'd0}},
    '{ROW_COUNT,     13'd4096, '{CMD_ALLOC, 12'd0},     '{ST_OK,    12'd0}},
    '{ROW_PREDICTED, 13'd0,    '{CMD_FREE,  12'hAAA},   '{ST_OK,    12'd0}},
    '{ROW_PREDICTED, 13'd0,    '{CMD_FREE,  12'h555},   '{ST_OK,    12'd0}},
    '{ROW_PREDICTED, 13'd0,    '{CMD_ALLOC, 12'd0},     '{ST_OK,    12'd0}}
  };

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               start       = 1'b0;
  logic               busy;
  req_t               req         = '0;
  logic               done_o;
  rsp_t               rsp_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [COUNT_W-1:0] cfg_data_i  = '0;

  // Shadow of the allocator state and the outcomes still to arrive.
  bit [MAP_BITS-1:0]  shadow_map   = '0;
  logic [COUNT_W-1:0] shadow_count = COUNT_RESET;
  int unsigned        live_blocks[$];
  rsp_t               expected_outcomes[$];

  int unsigned mismatches     = 0;
  int unsigned requests_sent  = 0;
  int unsigned count_writes   = 0;
  int unsigned allocs_granted = 0;
  int unsigned frees_done     = 0;
  int unsigned full_seen      = 0;
  int unsigned range_seen     = 0;
  int unsigned top_index      = 0;

  bitmap_block_allocator #(
    .MAP_BITS (MAP_BITS)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // Free-running clock.
  always #6 clk_i = ~clk_i;

  // One line per mismatch, with a cap on what is printed.
  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= PRINT_CAP) begin
      $display("MISMATCH at %0t ns: %s (got %0d, expected %0d)", $time, what, got, want);
    end
  endtask

  // Number of blocks that are actually searchable under the current count.
  function automatic int unsigned active_limit();
    int unsigned lim;
    lim = shadow_count;
    if (lim > MAP_BITS) lim = MAP_BITS;
    if (lim > INDEX_SPAN) lim = INDEX_SPAN;
    return lim;
  endfunction

  // Applies one command to the shadow bitmap and returns the outcome it must produce.
  function automatic rsp_t apply_command(input req_t r);
    rsp_t        outcome;
    int unsigned lim;
    lim = active_limit();
    outcome.status          = ST_FULL;
    outcome.allocated_index = '0;
    if (r.command == CMD_ALLOC) begin
      for (int unsigned i = 0; i < lim; i++) begin
        if (!shadow_map[i]) begin
          shadow_map[i]           = 1'b1;
          outcome.status          = ST_OK;
          outcome.allocated_index = 12'(i);
          live_blocks.push_back(i);
          if (i > top_index) top_index = i;
          break;
        end
      end
      if (outcome.status == ST_OK) allocs_granted++;
      else full_seen++;
    end else if (r.block_index >= lim) begin
      outcome.status = ST_RANGE;
      range_seen++;
    end else begin
      shadow_map[r.block_index] = 1'b0;
      outcome.status            = ST_OK;
      frees_done++;
      for (int j = 0; j < live_blocks.size(); j++) begin
        if (live_blocks[j] == r.block_index) begin
          live_blocks.delete(j);
          break;
        end
      end
    end
    return outcome;
  endfunction

  // Presents one command and waits until it is accepted; the expectation is queued on acceptance.
  task automatic issue_request(input req_t r, input bit typed, input rsp_t typed_rsp);
    rsp_t predicted;
    start <= 1'b1;
    req   <= r;
    do @(posedge clk_i); while (busy !== 1'b0);
    predicted = apply_command(r);
    expected_outcomes.push_back(typed ? typed_rsp : predicted);
    requests_sent++;
  endtask

  // Holds the sender off until every outstanding result has been seen.
  task automatic drain_outcomes();
    start <= 1'b0;
    while (expected_outcomes.size() != 0) @(posedge clk_i);
  endtask

  // Writes the block count register; only called with the allocator idle.
  task automatic write_block_count(input logic [COUNT_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i  <= 1'b0;
    shadow_count = value;
    count_writes++;
  endtask

  // Result checker: every strobe is matched against the oldest expectation.
  always @(posedge clk_i) begin : result_check
    rsp_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (expected_outcomes.size() == 0) begin
        report_mismatch("result with no outstanding command", int'(rsp_o.status), -1);
      end else begin
        want = expected_outcomes.pop_front();
        if (rsp_o.status !== want.status) begin
          report_mismatch("status", int'(rsp_o.status), int'(want.status));
        end
        if (rsp_o.allocated_index !== want.allocated_index) begin
          report_mismatch("allocated_index", int'(rsp_o.allocated_index),
                          int'(want.allocated_index));
        end
      end
    end
  end

  // Watchdog: ends the run after a long stretch with no transaction of any kind.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((start === 1'b1 && busy === 1'b0) || done_o === 1'b1 ||
          (cfg_valid_i === 1'b1 && cfg_ready_o === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Verification failed");
    $finish;
  end

  // Main sequence: reset, directed plan, randomised phases, drain.
  initial begin : stimulus
    req_t        r;
    int unsigned issued;
    int unsigned phase_len;
    int unsigned alloc_pct;
    int unsigned lim;
    int unsigned sel;
    bit          quiet_phase;
    logic [COUNT_W-1:0] count_pick;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed plan.
    foreach (DIRECTED_PLAN[n]) begin
      unique case (DIRECTED_PLAN[n].kind)
        ROW_COUNT: begin
          drain_outcomes();
          write_block_count(DIRECTED_PLAN[n].count);
        end
        ROW_TYPED: begin
          issue_request(DIRECTED_PLAN[n].req, 1'b1, DIRECTED_PLAN[n].rsp);
        end
        default: begin
          issue_request(DIRECTED_PLAN[n].req, 1'b0, '0);
        end
      endcase
    end

    // Random phases, each under a fresh block count written while idle.
    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      drain_outcomes();
      sel = $urandom_range(0, 19);
      unique case (sel)
        0:       count_pick = '0;
        1:       count_pick = 13'd4096;
        2:       count_pick = 13'd8191;
        3:       count_pick = 13'($urandom_range(4097, 8191));
        4:       count_pick = 13'($urandom_range(1, 4095));
        default: count_pick = 13'($urandom_range(1, 200));
      endcase
      write_block_count(count_pick);
      lim         = active_limit();
      phase_len   = $urandom_range(20, 90);
      alloc_pct   = $urandom_range(30, 80);
      quiet_phase = ($urandom_range(0, 3) == 0);

      // The closing stretch runs as one phase, so nothing idles inside it.
      if (RANDOM_ITEMS - issued > TAIL_ITEMS) begin
        if (phase_len > RANDOM_ITEMS - issued - TAIL_ITEMS) begin
          phase_len = RANDOM_ITEMS - issued - TAIL_ITEMS;
        end
      end else begin
        phase_len = RANDOM_ITEMS - issued;
      end

      for (int k = 0; k < phase_len && issued < RANDOM_ITEMS; k++) begin
        r.command = ($urandom_range(0, 99) < alloc_pct) ? CMD_ALLOC : CMD_FREE;
        if (r.command == CMD_ALLOC) begin
          r.block_index = 12'($urandom_range(0, 4095));
        end else begin
          // Mostly frees of live or in-range blocks, the rest anywhere in the field.
          sel = $urandom_range(0, 99);
          if (sel < 45 && live_blocks.size() > 0) begin
            r.block_index = 12'(live_blocks[$urandom_range(0, live_blocks.size() - 1)]);
          end else if (sel < 88 && lim > 0) begin
            r.block_index = 12'($urandom_range(0, lim - 1));
          end else begin
            r.block_index = 12'($urandom_range(0, 4095));
          end
        end
        issue_request(r, 1'b0, '0);
        issued++;

        // Sender gaps, none in the closing stretch.
        if (RANDOM_ITEMS - issued > TAIL_ITEMS && !quiet_phase) begin
          if ($urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk_i);
          end else if ($urandom_range(0, 59) == 0) begin
            drain_outcomes();
          end
        end
      end
    end

    // Let the last results arrive, then watch for stray strobes.
    drain_outcomes();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Run covered %0d commands and %0d block count settings from 0 up to 8191.",
             requests_sent, count_writes);
    $display("Seen: %0d blocks granted, %0d frees, %0d full, %0d out of range, top block %0d.",
             allocs_granted, frees_done, full_seen, range_seen, top_index);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
